>>> rtl/point_to_line_distance_core_macros.svh
// ----------------------------------------------------------------------------
// Point to line distance core: assertion macros
// Concurrent assertion wrappers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef POINT_TO_LINE_DISTANCE_CORE_MACROS_SVH
`define POINT_TO_LINE_DISTANCE_CORE_MACROS_SVH

`ifndef SYNTH
`define PTLD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("ptld assertion failed");
`define PTLD_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("ptld forbidden condition seen");
`else
`define PTLD_ASSERT(lbl, clk, rst_n, prop)
`define PTLD_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

>>> rtl/ptld_pkg.sv
// ----------------------------------------------------------------------------
// Point to line distance package
// Widths, stage counts and the control word shared by the pipeline stages.
// ----------------------------------------------------------------------------
package ptld_pkg;

  localparam int COORD_W   = 16;
  localparam int FRAC_BITS = 8;
  localparam int DIST_W    = 25;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int PROD_W    = 2 * DIFF_W;
  localparam int NUM_W     = PROD_W + 1;
  localparam int DEN_W     = PROD_W;
  localparam int NUM_LO_W  = (NUM_W + 1) / 2;
  localparam int NUM_HI_W  = NUM_W - NUM_LO_W;
  localparam int SQR_W     = 2 * NUM_W;
  localparam int R_W       = SQR_W + 2 * FRAC_BITS;
  localparam int QUO_W     = 2 * DIST_W;
  localparam int HEAD_W    = R_W - QUO_W;
  localparam int SQ_REM_W  = DIST_W + 2;
  localparam int IN_TDATA_W  = ((6 * COORD_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((DIST_W + 7) / 8) * 8;

  typedef struct packed {
    logic valid;
    logic degen;
    logic sat;
  } ctl_t;

endpackage

>>> rtl/ptld_div_stage.sv
// ----------------------------------------------------------------------------
// Point to line distance: division stage
// One restoring step of the squared-distance quotient, registered.
// ----------------------------------------------------------------------------
module ptld_div_stage (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  ptld_pkg::ctl_t               ctl_i,
  input  logic [ptld_pkg::DEN_W-1:0]   den_i,
  input  logic [ptld_pkg::DEN_W-1:0]   rem_i,
  input  logic [ptld_pkg::QUO_W-1:0]   word_i,
  output ptld_pkg::ctl_t               ctl_o,
  output logic [ptld_pkg::DEN_W-1:0]   den_o,
  output logic [ptld_pkg::DEN_W-1:0]   rem_o,
  output logic [ptld_pkg::QUO_W-1:0]   word_o
);

  logic [ptld_pkg::DEN_W:0]   trial;
  logic [ptld_pkg::DEN_W:0]   diff;
  logic                       ge;
  logic [ptld_pkg::DEN_W-1:0] rem_d;
  logic [ptld_pkg::QUO_W-1:0] word_d;
  ptld_pkg::ctl_t             ctl_q;
  logic [ptld_pkg::DEN_W-1:0] den_q;
  logic [ptld_pkg::DEN_W-1:0] rem_q;
  logic [ptld_pkg::QUO_W-1:0] word_q;

  always_comb begin
    trial  = {rem_i, word_i[ptld_pkg::QUO_W-1]};
    ge     = trial >= {1'b0, den_i};
    diff   = trial - {1'b0, den_i};
    rem_d  = ge ? diff[ptld_pkg::DEN_W-1:0] : trial[ptld_pkg::DEN_W-1:0];
    word_d = {word_i[ptld_pkg::QUO_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q  <= den_i;
      rem_q  <= rem_d;
      word_q <= word_d;
    end
  end

  assign ctl_o  = ctl_q;
  assign den_o  = den_q;
  assign rem_o  = rem_q;
  assign word_o = word_q;

endmodule

>>> rtl/ptld_sqrt_stage.sv
// ----------------------------------------------------------------------------
// Point to line distance: square root stage
// One digit of the restoring integer square root, registered.
// ----------------------------------------------------------------------------
module ptld_sqrt_stage (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  ptld_pkg::ctl_t                  ctl_i,
  input  logic [ptld_pkg::SQ_REM_W-1:0]   rem_i,
  input  logic [ptld_pkg::DIST_W-1:0]     root_i,
  input  logic [ptld_pkg::QUO_W-1:0]      word_i,
  output ptld_pkg::ctl_t                  ctl_o,
  output logic [ptld_pkg::SQ_REM_W-1:0]   rem_o,
  output logic [ptld_pkg::DIST_W-1:0]     root_o,
  output logic [ptld_pkg::QUO_W-1:0]      word_o
);

  logic [ptld_pkg::SQ_REM_W+1:0] acc;
  logic [ptld_pkg::SQ_REM_W-1:0] trial;
  logic [ptld_pkg::SQ_REM_W+1:0] diff;
  logic                          ge;
  logic [ptld_pkg::SQ_REM_W-1:0] rem_d;
  logic [ptld_pkg::DIST_W-1:0]   root_d;
  logic [ptld_pkg::QUO_W-1:0]    word_d;
  ptld_pkg::ctl_t                ctl_q;
  logic [ptld_pkg::SQ_REM_W-1:0] rem_q;
  logic [ptld_pkg::DIST_W-1:0]   root_q;
  logic [ptld_pkg::QUO_W-1:0]    word_q;

  always_comb begin
    acc    = {rem_i, word_i[ptld_pkg::QUO_W-1:ptld_pkg::QUO_W-2]};
    trial  = {root_i, 2'b01};
    ge     = acc >= {2'b00, trial};
    diff   = acc - {2'b00, trial};
    rem_d  = ge ? diff[ptld_pkg::SQ_REM_W-1:0] : acc[ptld_pkg::SQ_REM_W-1:0];
    root_d = {root_i[ptld_pkg::DIST_W-2:0], ge};
    word_d = {word_i[ptld_pkg::QUO_W-3:0], 2'b00};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
      word_q <= word_d;
    end
  end

  assign ctl_o  = ctl_q;
  assign rem_o  = rem_q;
  assign root_o = root_q;
  assign word_o = word_q;

endmodule

>>> rtl/point_to_line_distance_core.sv
// ----------------------------------------------------------------------------
// Point to line distance core
// Perpendicular distance from a query point to a line through two points.
//
// The slave stream carries one beat per query: two line points and the query
// point, six signed 16-bit coordinates. The master stream returns one beat per
// query: the distance as unsigned fixed point with 8 fraction bits, truncated,
// and a degenerate flag in tuser when the two line points coincide (distance
// then 0). Results leave in the order the queries came in.
// An accepted beat passes five front stages that form the coefficients,
// numerator, denominator and squared numerator, then 50 restoring division
// stages and 25 square root stages, one bit each, to its result beat.
// Throughput is one beat per cycle. The whole pipe advances on one enable, so
// a stall on the master side holds every stage and drops s_axis_tready; no
// beat is lost or repeated. Reset empties the pipe; no state survives it.
// ----------------------------------------------------------------------------
`include "point_to_line_distance_core_macros.svh"

module point_to_line_distance_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // line_start_x, line_start_y, line_end_x, line_end_y, query_x, query_y
  input  logic [ptld_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // distance_fixed, zero padding
  output logic [ptld_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // degenerate
  output logic                                m_axis_tuser
);

  localparam int CW = ptld_pkg::COORD_W;

  logic en;

  logic signed [CW-1:0] x1, y1, x2, y2, px, py;

  logic                                 v1_q, v2_q, v3_q, v4_q, v5_q;
  logic signed [ptld_pkg::DIFF_W-1:0]   a_q, b_q, dx_q, dy_q;
  logic signed [ptld_pkg::PROD_W-1:0]   p1_q, p2_q, aa_q, bb_q;
  logic signed [ptld_pkg::NUM_W-1:0]    s_sum;
  logic [ptld_pkg::NUM_W-1:0]           num_q;
  logic [ptld_pkg::DEN_W-1:0]           den3_q, den4_q, den5_q;
  logic                                 degen4_q, degen5_q;
  logic [2*ptld_pkg::NUM_HI_W-1:0]      hh_q;
  logic [ptld_pkg::NUM_W-1:0]           hl_q;
  logic [2*ptld_pkg::NUM_LO_W-1:0]      ll_q;
  logic [ptld_pkg::SQR_W-1:0]           sqr;
  logic [ptld_pkg::R_W-1:0]             r_q;
  logic [ptld_pkg::HEAD_W-1:0]          head;

  ptld_pkg::ctl_t                       init_ctl;

  ptld_pkg::ctl_t                       div_ctl  [0:ptld_pkg::QUO_W];
  logic [ptld_pkg::DEN_W-1:0]           div_den  [0:ptld_pkg::QUO_W];
  logic [ptld_pkg::DEN_W-1:0]           div_rem  [0:ptld_pkg::QUO_W];
  logic [ptld_pkg::QUO_W-1:0]           div_word [0:ptld_pkg::QUO_W];

  ptld_pkg::ctl_t                       sq_ctl  [0:ptld_pkg::DIST_W];
  logic [ptld_pkg::SQ_REM_W-1:0]        sq_rem  [0:ptld_pkg::DIST_W];
  logic [ptld_pkg::DIST_W-1:0]          sq_root [0:ptld_pkg::DIST_W];
  logic [ptld_pkg::QUO_W-1:0]           sq_word [0:ptld_pkg::DIST_W];

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  assign x1 = s_axis_tdata[1*CW-1:0*CW];
  assign y1 = s_axis_tdata[2*CW-1:1*CW];
  assign x2 = s_axis_tdata[3*CW-1:2*CW];
  assign y2 = s_axis_tdata[4*CW-1:3*CW];
  assign px = s_axis_tdata[5*CW-1:4*CW];
  assign py = s_axis_tdata[6*CW-1:5*CW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_comb begin
    s_sum = ptld_pkg::NUM_W'(p1_q) + ptld_pkg::NUM_W'(p2_q);
    sqr   = (ptld_pkg::SQR_W'(hh_q) << (2 * ptld_pkg::NUM_LO_W))
          + (ptld_pkg::SQR_W'(hl_q) << (ptld_pkg::NUM_LO_W + 1))
          + ptld_pkg::SQR_W'(ll_q);
    head  = r_q[ptld_pkg::R_W-1:ptld_pkg::QUO_W];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q  <= ptld_pkg::DIFF_W'(y2) - ptld_pkg::DIFF_W'(y1);
      b_q  <= ptld_pkg::DIFF_W'(x1) - ptld_pkg::DIFF_W'(x2);
      dx_q <= ptld_pkg::DIFF_W'(px) - ptld_pkg::DIFF_W'(x1);
      dy_q <= ptld_pkg::DIFF_W'(py) - ptld_pkg::DIFF_W'(y1);

      p1_q <= a_q * dx_q;
      p2_q <= b_q * dy_q;
      aa_q <= a_q * a_q;
      bb_q <= b_q * b_q;

      num_q  <= s_sum[ptld_pkg::NUM_W-1] ? ptld_pkg::NUM_W'(-s_sum)
                                         : ptld_pkg::NUM_W'(s_sum);
      den3_q <= $unsigned(aa_q) + $unsigned(bb_q);

      hh_q     <= num_q[ptld_pkg::NUM_W-1:ptld_pkg::NUM_LO_W]
                * num_q[ptld_pkg::NUM_W-1:ptld_pkg::NUM_LO_W];
      hl_q     <= num_q[ptld_pkg::NUM_W-1:ptld_pkg::NUM_LO_W]
                * num_q[ptld_pkg::NUM_LO_W-1:0];
      ll_q     <= num_q[ptld_pkg::NUM_LO_W-1:0] * num_q[ptld_pkg::NUM_LO_W-1:0];
      den4_q   <= den3_q;
      degen4_q <= den3_q == '0;

      r_q      <= {sqr, {(2 * ptld_pkg::FRAC_BITS){1'b0}}};
      den5_q   <= den4_q;
      degen5_q <= degen4_q;
    end
  end

  // saturate when the quotient would not fit the squared distance range
  always_comb begin
    init_ctl.valid = v5_q;
    init_ctl.degen = degen5_q;
    init_ctl.sat   = head >= ptld_pkg::HEAD_W'(den5_q);
  end

  assign div_ctl[0]  = init_ctl;
  assign div_den[0]  = den5_q;
  assign div_rem[0]  = head[ptld_pkg::DEN_W-1:0];
  assign div_word[0] = r_q[ptld_pkg::QUO_W-1:0];

  for (genvar i = 0; i < ptld_pkg::QUO_W; i++) begin : g_div
    ptld_div_stage u_div (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .ctl_i  (div_ctl[i]),
      .den_i  (div_den[i]),
      .rem_i  (div_rem[i]),
      .word_i (div_word[i]),
      .ctl_o  (div_ctl[i+1]),
      .den_o  (div_den[i+1]),
      .rem_o  (div_rem[i+1]),
      .word_o (div_word[i+1])
    );
  end

  assign sq_ctl[0]  = div_ctl[ptld_pkg::QUO_W];
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_word[0] = div_ctl[ptld_pkg::QUO_W].sat ? '1 : div_word[ptld_pkg::QUO_W];

  for (genvar j = 0; j < ptld_pkg::DIST_W; j++) begin : g_sqrt
    ptld_sqrt_stage u_sqrt (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .ctl_i  (sq_ctl[j]),
      .rem_i  (sq_rem[j]),
      .root_i (sq_root[j]),
      .word_i (sq_word[j]),
      .ctl_o  (sq_ctl[j+1]),
      .rem_o  (sq_rem[j+1]),
      .root_o (sq_root[j+1]),
      .word_o (sq_word[j+1])
    );
  end

  assign m_axis_tvalid = sq_ctl[ptld_pkg::DIST_W].valid;
  assign m_axis_tuser  = sq_ctl[ptld_pkg::DIST_W].degen;
  assign m_axis_tdata  = ptld_pkg::OUT_TDATA_W'(
                           sq_ctl[ptld_pkg::DIST_W].degen ? '0 : sq_root[ptld_pkg::DIST_W]);

  `PTLD_ASSERT(a_ready_follows_stall, clk_i, rst_ni,
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
  `PTLD_ASSERT(a_degen_gives_zero, clk_i, rst_ni,
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
  `PTLD_ASSERT_NEVER(a_pad_bits_zero, clk_i, rst_ni,
    m_axis_tvalid && (m_axis_tdata[ptld_pkg::OUT_TDATA_W-1:ptld_pkg::DIST_W] != '0))
  `PTLD_ASSERT(a_stall_holds_pipe, clk_i, rst_ni,
    (m_axis_tvalid && !m_axis_tready) |=> ($stable(m_axis_tdata) && m_axis_tvalid))

endmodule
